// ===== rtl/apc_pkg.sv =====
// Shared types, widths and helpers for the alpha premultiply converter.
// No dependencies; used by apc_lane and alpha_premultiply_convert_unit.
package apc_pkg;

  // Field widths
  localparam int CHAN_W  = 16;
  localparam int ALPHA_W = 8;

  // Mode codes
  localparam logic MODE_PREMUL   = 1'b0;
  localparam logic MODE_UNPREMUL = 1'b1;

  // Divider geometry: quotient bit 8 flags saturation, bits 7..0 are the result
  localparam int QUO_W           = 9;
  localparam int REM_W           = 24;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  // Input register plus the divide stages
  localparam int LATENCY = DIV_STAGES + 1;

  localparam logic [CHAN_W-1:0] SAT8 = CHAN_W'(255);

  // One stage register of a channel lane
  typedef struct packed {
    logic              mode;
    logic [REM_W-1:0]  rem;   // partial remainder, or final value in premultiply mode
    logic [QUO_W-1:0]  quo;
    logic [CHAN_W-1:0] den;   // 257 * max(alpha, 1)
  } lane_stage_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             hit;
  } div_step_t;

  // One restoring division step at quotient bit k
  function automatic div_step_t div_step(input logic [REM_W-1:0] rem,
                                         input logic [CHAN_W-1:0] den,
                                         input logic [3:0] k);
    logic [REM_W-1:0] sh;
    div_step_t        res;
    sh = REM_W'(den) << k;
    if (rem >= sh) begin
      res.rem = rem - sh;
      res.hit = 1'b1;
    end else begin
      res.rem = rem;
      res.hit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== rtl/alpha_premultiply_convert_unit.sv =====
// A pixel taken at a clock edge passes the input register and the three divide stages;
// its result is then on the outputs, with done high, for one cycle only.
// Throughput: one pixel per clock, sustained; busy is low outside reset.
// The lanes run a three-stage restoring divider, three quotient bits a stage.
// Reset (rst, synchronous) clears the valid pipeline; busy stays high during it.
// Top level: valid pipeline and three channel lanes. Depends on apc_pkg, apc_lane.
module alpha_premultiply_convert_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [apc_pkg::CHAN_W-1:0]  red_in,
  input  logic [apc_pkg::CHAN_W-1:0]  green_in,
  input  logic [apc_pkg::CHAN_W-1:0]  blue_in,
  input  logic [apc_pkg::ALPHA_W-1:0] alpha_in,
  input  logic                        end_of_span,
  output logic                        done,
  output logic [apc_pkg::CHAN_W-1:0]  red_out,
  output logic [apc_pkg::CHAN_W-1:0]  green_out,
  output logic [apc_pkg::CHAN_W-1:0]  blue_out,
  output logic [apc_pkg::ALPHA_W-1:0] alpha_out,
  output logic                        span_last
);

  localparam int LAT = apc_pkg::LATENCY;

  logic                        take;
  logic [LAT-1:0]              vld;
  logic [apc_pkg::ALPHA_W-1:0] alpha_d [LAT];
  logic [LAT-1:0]              span_d;

  assign busy = rst;
  assign take = start & ~busy;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], take};
    end
  end

  // Sideband delay line for alpha and span mark
  always_ff @(posedge clk) begin
    alpha_d[0] <= alpha_in;
    span_d     <= {span_d[LAT-2:0], end_of_span};
    for (int i = 1; i < LAT; i++) begin
      alpha_d[i] <= alpha_d[i-1];
    end
  end

  // Channel lanes
  apc_lane u_red (
    .clk      (clk),
    .mode     (mode),
    .chan_in  (red_in),
    .alpha    (alpha_in),
    .chan_out (red_out)
  );

  apc_lane u_green (
    .clk      (clk),
    .mode     (mode),
    .chan_in  (green_in),
    .alpha    (alpha_in),
    .chan_out (green_out)
  );

  apc_lane u_blue (
    .clk      (clk),
    .mode     (mode),
    .chan_in  (blue_in),
    .alpha    (alpha_in),
    .chan_out (blue_out)
  );

  assign done      = vld[LAT-1];
  assign alpha_out = alpha_d[LAT-1];
  assign span_last = span_d[LAT-1];

  // Checks
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, 4))
    else $error("done without a transfer four cycles earlier");

  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> alpha_out == $past(alpha_in, 4))
    else $error("alpha not passed through");

  a_unpremul_sat: assert property (@(posedge clk) disable iff (rst)
    (done && $past(mode, 4) == apc_pkg::MODE_UNPREMUL) |->
      (red_out <= apc_pkg::SAT8 && green_out <= apc_pkg::SAT8 &&
       blue_out <= apc_pkg::SAT8))
    else $error("unpremultiply result above 255");

  a_premul_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && $past(mode, 4) == apc_pkg::MODE_PREMUL && $past(alpha_in, 4) == '0) |->
      (red_out == '0 && green_out == '0 && blue_out == '0))
    else $error("premultiply with zero alpha gave nonzero colour");

endmodule

// ===== rtl/apc_lane.sv =====
// One colour channel of the converter: input products, then a pipelined
// restoring divider for unpremultiply. Depends on apc_pkg.
module apc_lane (
  input  logic                        clk,
  input  logic                        mode,
  input  logic [apc_pkg::CHAN_W-1:0]  chan_in,
  input  logic [apc_pkg::ALPHA_W-1:0] alpha,
  output logic [apc_pkg::CHAN_W-1:0]  chan_out
);

  localparam int NSTG = apc_pkg::DIV_STAGES + 1;

  apc_pkg::lane_stage_t st  [NSTG];
  apc_pkg::lane_stage_t s0;

  logic [apc_pkg::ALPHA_W-1:0] alpha_eff;
  logic [apc_pkg::CHAN_W-1:0]  prod;

  // Entry: 8x8 product for premultiply, c*255 and 257*max(a,1) for unpremultiply
  always_comb begin
    alpha_eff = (alpha == '0) ? apc_pkg::ALPHA_W'(1) : alpha;
    prod      = apc_pkg::CHAN_W'(chan_in[7:0]) * apc_pkg::CHAN_W'(alpha);
    s0.mode   = mode;
    s0.quo    = '0;
    s0.den    = {alpha_eff, alpha_eff};
    if (mode == apc_pkg::MODE_UNPREMUL) begin
      s0.rem = {chan_in, 8'b0} - apc_pkg::REM_W'(chan_in);
    end else begin
      s0.rem = apc_pkg::REM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= s0;
  end

  // Divide stages, three quotient bits each
  for (genvar j = 0; j < apc_pkg::DIV_STAGES; j++) begin : g_stage
    apc_pkg::lane_stage_t nxt;
    apc_pkg::div_step_t   ds;
    logic [15:0] p;
    logic [24:0] t;
    logic [8:0]  q0;
    logic [16:0] r;
    logic [8:0]  q;
    logic [3:0]  k;

    always_comb begin
      nxt = st[j];
      ds  = '0;
      k   = '0;
      p   = st[j].rem[15:0];
      t   = {p, 9'b0} + {8'b0, p, 1'b0};
      q0  = t[24:16];
      r   = {p, 1'b0} - ({q0, 8'b0} - 17'(q0));
      q   = q0 + ((r >= 17'd255) ? 9'd1 : 9'd0);
      if (st[j].mode == apc_pkg::MODE_UNPREMUL) begin
        for (int s = 0; s < apc_pkg::STEPS_PER_STAGE; s++) begin
          k = 4'(apc_pkg::QUO_W - 1 - j * apc_pkg::STEPS_PER_STAGE - s);
          ds = apc_pkg::div_step(nxt.rem, nxt.den, k);
          nxt.rem    = ds.rem;
          nxt.quo[k] = ds.hit;
        end
      end else if (j == 0) begin
        // p*257/255 = p + floor(2p/255); reciprocal estimate plus one correction
        nxt.rem = apc_pkg::REM_W'(p + 16'(q));
      end
    end

    always_ff @(posedge clk) begin
      st[j+1] <= nxt;
    end
  end

  // Result select with saturation
  always_comb begin
    if (st[NSTG-1].mode == apc_pkg::MODE_UNPREMUL) begin
      chan_out = st[NSTG-1].quo[8] ? apc_pkg::SAT8
                                   : apc_pkg::CHAN_W'(st[NSTG-1].quo[7:0]);
    end else begin
      chan_out = st[NSTG-1].rem[apc_pkg::CHAN_W-1:0];
    end
  end

endmodule
